[hw/rtl/swa_pkg.sv]
// Shared types and constants for the sliding window average unit.
// Holds the sequencer state type and the register map of the configuration port.
// No dependencies.
`default_nettype none

package swa_pkg;

	// Configuration register file.
	localparam int unsigned CFG_W     = 7;
	localparam int unsigned ADDR_W    = 3;
	localparam int unsigned PDATA_W   = 32;
	localparam logic [ADDR_W-1:0] ADDR_WINDOW_SIZE = 3'd0;
	localparam logic [CFG_W-1:0]  WINDOW_SIZE_RESET = 7'd8;

	// Fraction bits of the average.
	localparam int unsigned FRAC_BITS = 8;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_UPD  = 5'b00010,
		ST_PREP = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} swa_state_t;

endpackage

`default_nettype wire

[hw/rtl/sliding_window_average_unit.sv]
// Top level of the sliding window average unit: ring store, running sum and a
// bit-serial restoring divider under one sequencer.
// Depends on swa_pkg.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------
//  input   | in        | in_valid / in_stall       | sample
//  output  | out       | out_valid / out_stall     | average, held_count
//  config  | in        | psel, penable, pwrite     | paddr, pwdata, prdata
//
// Each item passes the update, prepare, divide and done states before the next is taken;
// the divider in the divide state yields one quotient bit per cycle.
// Reset empties the window and sets the window size to 8; the ring needs no clearing.
// A result waits in the output register; the next item is taken while it waits.
// A finished quotient is held until the output register is free.
`default_nettype none

module sliding_window_average_unit
	import swa_pkg::*;
#(
	parameter int unsigned MAX_WINDOW  = 64,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    psel,
	input  wire logic                                    penable,
	input  wire logic                                    pwrite,
	input  wire logic [ADDR_W-1:0]                       paddr,
	input  wire logic [PDATA_W-1:0]                      pwdata,
	output logic      [PDATA_W-1:0]                      prdata,
	output logic                                         pready,
	input  wire logic                                    in_valid,
	output logic                                         in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]           sample,
	output logic                                         out_valid,
	input  wire logic                                    out_stall,
	output logic signed [SAMPLE_BITS+FRAC_BITS-1:0]      average,
	output logic [$clog2(MAX_WINDOW+1)-1:0]              held_count
);

	localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int unsigned IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int unsigned WIN_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int unsigned SUM_W = SAMPLE_BITS + IDX_W;
	localparam int unsigned DVD_W = SUM_W + FRAC_BITS;
	localparam int unsigned AVG_W = SAMPLE_BITS + FRAC_BITS;
	localparam int unsigned STEP_W = $clog2(DVD_W);
	localparam logic [WIN_W-1:0]  MAX_WIN_VAL = WIN_W'(MAX_WINDOW);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

	swa_state_t state_q;

	logic [CFG_W-1:0]              window_size_q;
	logic [IDX_W-1:0]              oldest_q;
	logic [CNT_W-1:0]              fill_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic [SAMPLE_BITS-1:0]        sample_q;
	logic [SAMPLE_BITS-1:0]        old_q;
	logic [SAMPLE_BITS-1:0]        sample_ring_q [MAX_WINDOW];
	logic                          neg_q;
	logic [DVD_W-1:0]              dvd_q;
	logic [CNT_W-1:0]              rem_q;
	logic [STEP_W-1:0]             step_q;
	logic                          out_valid_q;
	logic [AVG_W-1:0]              average_q;
	logic [CNT_W-1:0]              held_q;

	logic                          cfg_write;
	logic                          in_xfer;
	logic                          out_free;
	logic [WIN_W-1:0]              ws_ext;
	logic [CNT_W-1:0]              win;
	logic                          full;
	logic [CNT_W:0]                slot_sum;
	logic [CNT_W:0]                slot_wrap;
	logic [IDX_W-1:0]              slot;
	logic [CNT_W:0]                oldest_inc;
	logic signed [SUM_W-1:0]       sample_ext;
	logic signed [SUM_W-1:0]       old_ext;
	logic [SUM_W-1:0]              sum_mag;
	logic [CNT_W:0]                rem_shift;
	logic [CNT_W+1:0]              trial;
	logic                          qbit;
	logic [DVD_W-1:0]              quot_signed;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr == ADDR_WINDOW_SIZE);
	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_WINDOW_SIZE) begin
			prdata[CFG_W-1:0] = window_size_q;
		end
	end

	// A size of zero acts as one; anything above the ring depth acts as the depth.
	always_comb begin
		ws_ext = WIN_W'(window_size_q);
		if (ws_ext == '0) begin
			win = CNT_W'(1);
		end else if (ws_ext > MAX_WIN_VAL) begin
			win = CNT_W'(MAX_WINDOW);
		end else begin
			win = ws_ext[CNT_W-1:0];
		end
	end

	assign full       = (fill_q == win);
	assign slot_sum   = {1'b0, fill_q} + (CNT_W+1)'(oldest_q);
	assign slot_wrap  = (slot_sum >= {1'b0, win}) ? (slot_sum - {1'b0, win}) : slot_sum;
	assign slot       = full ? oldest_q : slot_wrap[IDX_W-1:0];
	assign oldest_inc = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(1);
	assign sample_ext = SUM_W'($signed(sample_q));
	assign old_ext    = SUM_W'($signed(old_q));
	assign sum_mag    = sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;

	// One restoring division step: shift in the next dividend bit, try the divisor.
	assign rem_shift   = {rem_q, dvd_q[DVD_W-1]};
	assign trial       = {1'b0, rem_shift} - {2'b00, fill_q};
	assign qbit        = !trial[CNT_W+1];
	assign quot_signed = neg_q ? (DVD_W'(0) - dvd_q) : dvd_q;

	// Ring store with a registered read port.
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			sample_ring_q[slot] <= sample_q;
		end
		if (in_xfer) begin
			old_q    <= sample_ring_q[oldest_q];
			sample_q <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			window_size_q <= WINDOW_SIZE_RESET;
			oldest_q      <= '0;
			fill_q        <= '0;
			sum_q         <= '0;
			step_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				window_size_q <= pwdata[CFG_W-1:0];
				oldest_q      <= '0;
				fill_q        <= '0;
				sum_q         <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (full) begin
						sum_q <= sum_q - old_ext + sample_ext;
						oldest_q <= (oldest_inc >= {1'b0, win}) ? '0 : oldest_inc[IDX_W-1:0];
					end else begin
						sum_q  <= sum_q + sample_ext;
						fill_q <= fill_q + CNT_W'(1);
					end
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == LAST_STEP) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Divider datapath and result register.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_PREP: begin
				neg_q <= sum_q[SUM_W-1];
				dvd_q <= {sum_mag, FRAC_BITS'(0)};
				rem_q <= '0;
			end
			ST_DIV: begin
				dvd_q <= {dvd_q[DVD_W-2:0], qbit};
				rem_q <= qbit ? trial[CNT_W-1:0] : rem_shift[CNT_W-1:0];
			end
			ST_DONE: begin
				if (out_free) begin
					average_q <= quot_signed[AVG_W-1:0];
					held_q    <= fill_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign average    = $signed(average_q);
	assign held_count = held_q;

	// The window never holds more samples than its size.
	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= win)
		else $error("fill count exceeds the active window");

	// The divider never runs with an empty window as divisor.
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == ST_DIV) |-> (fill_q != '0))
		else $error("division by an empty window");

	// A transfer on the input side closes the input until the item is done.
	assert property (@(posedge clk) disable iff (!arst_n) in_xfer |=> in_stall)
		else $error("input reopened right after a transfer");

	// A pending result is never overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(average_q) && $stable(held_q)))
		else $error("pending result lost");

	// The oldest slot always lies inside the window.
	assert property (@(posedge clk) disable iff (!arst_n) (CNT_W+1)'(oldest_q) < {1'b0, win})
		else $error("oldest slot outside the window");

endmodule

`default_nettype wire

[sim/tb_sliding_window_average_unit.sv]
// Self-checking testbench for sliding_window_average_unit: a directed table, then random samples
// under random stalls, each result checked against a table value or a behavioral moving-average predictor.
// Depends on swa_pkg and the RTL of the unit.
`default_nettype none

module tb_sliding_window_average_unit
	import swa_pkg::*;
();

	localparam int RING_DEPTH = 64;
	localparam int SAMPLE_W = 16;
	localparam int MEAN_W = SAMPLE_W + FRAC_BITS;
	localparam int COUNT_W = $clog2(RING_DEPTH + 1);
	localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
	localparam int SETTLE_CYCLES = 60;
	localparam int RANDOM_ITEMS = 1400;
	localparam int SCRIPT_LEN = 25;

	typedef struct packed {
		logic signed [MEAN_W-1:0] average;
		logic [COUNT_W-1:0] held_count;
	} mean_t;

	typedef enum logic [1:0] {
		ROW_SAMPLE,
		ROW_SET_WINDOW,
		ROW_UNMAPPED_WRITE
	} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [31:0] value;
		bit typed;
		logic [MEAN_W-1:0] want_avg;
		logic [COUNT_W-1:0] want_cnt;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [MEAN_W-1:0] average;
	logic [COUNT_W-1:0] held_count;

	// Predictor state: a copy of the window kept alongside the unit.
	logic [CFG_W-1:0] win_size = WINDOW_SIZE_RESET;
	longint ring_mem [RING_DEPTH];
	int head_slot = 0;
	int held = 0;
	longint window_sum = 0;

	mean_t pending_means [$];
	int fail_count = 0;
	bit quiet = 1'b0;
	int stall_left = 0;
	row_t script [SCRIPT_LEN];

	sliding_window_average_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.average    (average),
		.held_count (held_count)
	);

	always #10 clk = ~clk;

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic void clear_window();
		head_slot = 0;
		held = 0;
		window_sum = 0;
	endfunction

	function automatic mean_t advance_window(input logic signed [SAMPLE_W-1:0] s);
		int w;
		int slot;
		longint scaled;
		mean_t r;
		w = (win_size == 0) ? 1 : (win_size > RING_DEPTH) ? RING_DEPTH : int'(win_size);
		if (head_slot >= w)
			head_slot = 0;
		if (held > w)
			held = w;
		if (held == w) begin
			slot = head_slot;
			window_sum -= ring_mem[slot];
			head_slot = (head_slot + 1 >= w) ? 0 : head_slot + 1;
		end else begin
			slot = head_slot + held;
			if (slot >= w)
				slot -= w;
			held++;
		end
		ring_mem[slot] = s;
		window_sum += s;
		scaled = window_sum * 256;
		r.average = MEAN_W'(scaled / held);
		r.held_count = COUNT_W'(held);
		return r;
	endfunction

	function automatic logic [SAMPLE_W-1:0] draw_sample();
		logic [SAMPLE_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = 16'h7FFF;
			1: v = 16'h8000;
			2: begin
				v = SAMPLE_W'($urandom_range(0, 8));
				v = v - 16'd4;
			end
			default: v = SAMPLE_W'($urandom);
		endcase
		return v;
	endfunction

	task automatic wait_drained();
		while (pending_means.size() != 0)
			@(posedge clk);
	endtask

	// Called on a clock edge; returns on a later edge with the bus released.
	task automatic apb_cycle(input bit wr, input logic [ADDR_W-1:0] addr,
		input logic [PDATA_W-1:0] data, output logic [PDATA_W-1:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_window_reg();
		logic [PDATA_W-1:0] rd;
		apb_cycle(1'b0, ADDR_WINDOW_SIZE, '0, rd);
		if (rd !== PDATA_W'(win_size)) begin
			$error("prdata: expected %0d, got %0d", win_size, rd);
			fail_count++;
		end
	endtask

	// Writes happen only with the unit idle, so the input side is lowered and drained first.
	task automatic set_window(input logic [ADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		logic [PDATA_W-1:0] rd;
		in_valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_cycle(1'b1, addr, data, rd);
		if (addr == ADDR_WINDOW_SIZE) begin
			win_size = data[CFG_W-1:0];
			clear_window();
		end
		check_window_reg();
	endtask

	task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed, input mean_t want);
		mean_t predicted;
		in_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (in_stall);
		predicted = advance_window(s);
		pending_means.push_back(typed ? want : predicted);
		if (!quiet && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left = stall_left - 1;
		else if (!quiet && $urandom_range(0, 99) < 15)
			stall_left = $urandom_range(1, 10);
		out_stall <= (stall_left > 0);
	end

	always @(posedge clk) begin : watch_results
		mean_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_means.size() == 0) begin
				$error("unexpected transfer: average %0d, held_count %0d", average, held_count);
				fail_count++;
			end else begin
				want = pending_means.pop_front();
				if (average !== want.average) begin
					$error("average: expected %0d, got %0d", want.average, average);
					fail_count++;
				end
				if (held_count !== want.held_count) begin
					$error("held_count: expected %0d, got %0d", want.held_count, held_count);
					fail_count++;
				end
			end
		end
	end

	initial begin : stimulus
		int sent;
		int phase;
		int len;
		logic [CFG_W-1:0] val;
		logic [PDATA_W-1:0] d;

		script = '{
			'{ROW_SAMPLE, 32'h7FFF, 1'b1, 24'h7FFF00, 7'd1},
			'{ROW_SAMPLE, 32'h8000, 1'b1, 24'hFFFF80, 7'd2},
			'{ROW_SAMPLE, 32'h0000, 1'b0, '0, '0},
			'{ROW_SAMPLE, 32'hFFFF, 1'b0, '0, '0},
			'{ROW_SET_WINDOW, 32'd1, 1'b0, '0, '0},
			'{ROW_SAMPLE, 32'h8000, 1'b1, 24'h800000, 7'd1},
			'{ROW_SAMPLE, 32'h7FFF, 1'b1, 24'h7FFF00, 7'd1},
			// A window size of zero behaves as a window of one.
			'{ROW_SET_WINDOW, 32'd0, 1'b0, '0, '0},
			'{ROW_SAMPLE, 32'h0005, 1'b1, 24'h000500, 7'd1},
			'{ROW_SAMPLE, 32'hFFFB, 1'b1, 24'hFFFB00, 7'd1},
			'{ROW_SET_WINDOW, 32'd3, 1'b0, '0, '0},
			'{ROW_SAMPLE, 32'hFFFF, 1'b1, 24'hFFFF00, 7'd1},
			'{ROW_SAMPLE, 32'h0000, 1'b1, 24'hFFFF80, 7'd2},
			// A negative mean truncates toward zero here.
			'{ROW_SAMPLE, 32'h0000, 1'b0, '0, '0},
			'{ROW_SAMPLE, 32'h0007, 1'b0, '0, '0},
			// A write to an unmapped address must leave the window alone.
			'{ROW_UNMAPPED_WRITE, 32'h0000_0001, 1'b0, '0, '0},
			'{ROW_SAMPLE, 32'h0001, 1'b0, '0, '0},
			// Rewriting the same size still clears the window.
			'{ROW_SET_WINDOW, 32'd3, 1'b0, '0, '0},
			'{ROW_SAMPLE, 32'h0009, 1'b1, 24'h000900, 7'd1},
			'{ROW_SET_WINDOW, 32'd127, 1'b0, '0, '0},
			'{ROW_SAMPLE, 32'h7FFF, 1'b1, 24'h7FFF00, 7'd1},
			'{ROW_SAMPLE, 32'h7FFF, 1'b0, '0, '0},
			'{ROW_SET_WINDOW, 32'hFFFF_FFC0, 1'b0, '0, '0},
			'{ROW_SAMPLE, 32'h8000, 1'b1, 24'h800000, 7'd1},
			'{ROW_SET_WINDOW, 32'd8, 1'b0, '0, '0}
		};

		foreach (ring_mem[i])
			ring_mem[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_window_reg();

		for (int k = 0; k < SCRIPT_LEN; k++) begin
			case (script[k].kind)
				ROW_SAMPLE: send_sample(script[k].value[SAMPLE_W-1:0], script[k].typed,
					{script[k].want_avg, script[k].want_cnt});
				ROW_SET_WINDOW: set_window(ADDR_WINDOW_SIZE, script[k].value);
				ROW_UNMAPPED_WRITE: set_window(ADDR_UNMAPPED, script[k].value);
				default: ;
			endcase
		end

		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			phase++;
			case ($urandom_range(0, 7))
				0: val = 7'd1;
				1: val = 7'd64;
				2: val = 7'd0;
				3: val = 7'd127;
				4: val = CFG_W'($urandom_range(65, 126));
				5: val = 7'd2;
				default: val = CFG_W'($urandom_range(2, 63));
			endcase
			d = $urandom;
			if ($urandom_range(0, 1))
				d[PDATA_W-1:CFG_W] = '0;
			d[CFG_W-1:0] = val;
			if ($urandom_range(0, 5) == 0)
				set_window(ADDR_UNMAPPED, $urandom);
			set_window(ADDR_WINDOW_SIZE, d);
			// The tail of the run goes without input gaps or output stalls, as do some random stretches.
			quiet = (RANDOM_ITEMS - sent < 200) || ($urandom_range(0, 4) == 0);
			len = (win_size >= 32) ? $urandom_range(80, 200) : $urandom_range(20, 120);
			for (int i = 0; i < len; i++) begin
				send_sample(draw_sample(), 1'b0, '0);
				sent++;
				if (phase == 3 && i == len / 2) begin
					in_valid <= 1'b0;
					wait_drained();
				end
			end
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_means.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
